// ----- src/hufd_pkg.sv -----
// ----------------------------------------------------------------------------
// hufd_pkg
// shared types and constants of the huffman tree walk decoder
// ----------------------------------------------------------------------------
package hufd_pkg;

    localparam int IDX_W          = 9;
    localparam int SYM_W          = 8;
    localparam int CNT_W          = 64;
    localparam int BYTE_BITS      = 8;
    localparam int BITS_W         = 4;
    localparam int NODE_COUNT_DEF = 512;
    localparam int ENTRY_W        = 28;

    // request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_DECODE  = 2'd1,
        REQ_RESTART = 2'd2
    } req_e_t;

    // register select, paddr bit 3
    localparam logic CFG_REG_TOTAL = 1'b0;
    localparam logic CFG_REG_ROOT  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    // where the current node entry comes from in a walk cycle
    typedef enum logic [1:0] {
        SRC_ROOT,
        SRC_FIRST,
        SRC_CHILD
    } src_t;

    typedef struct packed {
        logic             right_absent;
        logic [IDX_W-1:0] right;
        logic [IDX_W-1:0] left;
        logic [SYM_W-1:0] symbol;
        logic             leaf;
    } node_entry_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             finished;
        logic             bad_path;
    } res_t;

endpackage

// ----- src/hufd_node_ram.sv -----
// ----------------------------------------------------------------------------
// hufd_node_ram
// node table: one write port, two registered read ports, entries beyond the
// table depth read as zero and ignore writes
// ----------------------------------------------------------------------------
module hufd_node_ram
    import hufd_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  node_entry_t      wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx_a,
    input  logic [IDX_W-1:0] rd_idx_b,
    output node_entry_t      rd_data_a,
    output node_entry_t      rd_data_b
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    node_entry_t mem [NODE_COUNT];
    node_entry_t rd_a_reg;
    node_entry_t rd_b_reg;
    logic        ok_a_reg;
    logic        ok_b_reg;

    logic wr_ok;
    logic ok_a;
    logic ok_b;

    assign wr_ok = 32'(wr_idx) < 32'(NODE_COUNT);
    assign ok_a  = 32'(rd_idx_a) < 32'(NODE_COUNT);
    assign ok_b  = 32'(rd_idx_b) < 32'(NODE_COUNT);

    always_ff @(posedge aclk) begin
        if (wr_en && wr_ok) begin
            mem[AW'(wr_idx)] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem[AW'(rd_idx_a)];
            rd_b_reg <= mem[AW'(rd_idx_b)];
            ok_a_reg <= ok_a;
            ok_b_reg <= ok_b;
        end
    end

    assign rd_data_a = ok_a_reg ? rd_a_reg : '0;
    assign rd_data_b = ok_b_reg ? rd_b_reg : '0;

endmodule

// ----- src/huffman_tree_decoder.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// huffman decoder walking a code tree held in a node table
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_        in         tuser: req_type; tdata: code_byte, node_index,
//                       node_is_leaf, node_symbol, left_child, right_child,
//                       right_absent
//  m_        out        tdata: symbol; tlast: last; tuser: finished, bad_path
//  apb       in/out     0x0 total_symbols (64 bit), 0x8 root_index
//
//  a code byte is accepted, walked bit by bit and its last word flushed; the walk
//  ends early once the total is hit; each bit that does not take a missing right
//  child waits on one read of the node table
//  reset is synchronous; the node table is not cleared and needs no sweep
//  a full output register stalls the walk
// ----------------------------------------------------------------------------
module huffman_tree_decoder
    import hufd_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // code_byte, node_index, node_is_leaf, node_symbol,
                                   // left_child, right_child, right_absent, zero pad
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // symbol
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // finished, bad_path
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    state_t           state_reg,       state_next;
    src_t             src_reg,         src_next;
    logic [SYM_W-1:0] byte_reg,        byte_next;
    logic [BITS_W-1:0] bits_left_reg,  bits_left_next;
    logic [IDX_W-1:0] cur_idx_reg,     cur_idx_next;
    logic [IDX_W-1:0] child_idx_reg,   child_idx_next;
    node_entry_t      root_entry_reg,  root_entry_next;
    logic [CNT_W-1:0] count_reg,       count_next;
    logic [CNT_W-1:0] total_reg,       total_next;
    logic [IDX_W-1:0] root_reg,        root_next;
    logic             pend_valid_reg,  pend_valid_next;
    res_t             pend_reg,        pend_next;
    logic             m_valid_reg,     m_valid_next;
    res_t             m_res_reg,       m_res_next;
    logic             m_last_reg,      m_last_next;

    logic             ram_wr_en;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_idx_a;
    node_entry_t      ram_wr_data;
    node_entry_t      rd_a;
    node_entry_t      rd_b;

    node_entry_t      root_now;
    node_entry_t      cur_now;
    logic             leaf_hit;
    logic             bad_hit;
    logic             res_hit;
    logic             fin_hit;
    logic             out_free;
    logic             stall;
    logic             cfg_wr;
    logic [CNT_W-1:0] count_inc;
    logic [IDX_W-1:0] child_idx;
    req_e_t           req;

    assign req = req_e_t'(s_tuser);

    assign ram_wr_data.leaf         = s_tdata[17];
    assign ram_wr_data.symbol       = s_tdata[25:18];
    assign ram_wr_data.left         = s_tdata[34:26];
    assign ram_wr_data.right        = s_tdata[43:35];
    assign ram_wr_data.right_absent = s_tdata[44];

    hufd_node_ram #(
        .NODE_COUNT(NODE_COUNT)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (ram_wr_en),
        .wr_idx    (s_tdata[16:8]),
        .wr_data   (ram_wr_data),
        .rd_en     (ram_rd_en),
        .rd_idx_a  (ram_rd_idx_a),
        .rd_idx_b  (root_reg),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[3] == CFG_REG_ROOT) ? CNT_W'(root_reg) : total_reg;

    assign root_now  = (src_reg == SRC_FIRST) ? rd_b : root_entry_reg;
    assign cur_now   = (src_reg == SRC_ROOT) ? root_entry_reg : rd_a;
    assign leaf_hit  = (state_reg == ST_WALK) && (src_reg == SRC_CHILD) && rd_a.leaf;
    assign bad_hit   = (state_reg == ST_WALK) && !leaf_hit && (bits_left_reg != '0)
                       && byte_reg[SYM_W-1] && cur_now.right_absent;
    assign res_hit   = leaf_hit || bad_hit;
    assign count_inc = count_reg + CNT_W'(1);
    assign fin_hit   = count_inc >= total_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign stall     = res_hit && pend_valid_reg && !out_free;
    assign child_idx = byte_reg[SYM_W-1] ? cur_now.right : cur_now.left;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            src_reg        <= SRC_ROOT;
            bits_left_reg  <= '0;
            cur_idx_reg    <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            root_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            src_reg        <= src_next;
            bits_left_reg  <= bits_left_next;
            cur_idx_reg    <= cur_idx_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            root_reg       <= root_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg       <= byte_next;
        child_idx_reg  <= child_idx_next;
        root_entry_reg <= root_entry_next;
        pend_reg       <= pend_next;
        m_res_reg      <= m_res_next;
        m_last_reg     <= m_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        src_next        = src_reg;
        byte_next       = byte_reg;
        bits_left_next  = bits_left_reg;
        cur_idx_next    = cur_idx_reg;
        child_idx_next  = child_idx_reg;
        root_entry_next = root_entry_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        root_next       = root_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_res_next      = m_res_reg;
        m_last_next     = m_last_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_rd_idx_a    = cur_idx_reg;
        s_tready        = (state_reg == ST_IDLE);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (req)
                        REQ_WRITE: begin
                            ram_wr_en = 1'b1;
                        end
                        REQ_RESTART: begin
                            count_next   = '0;
                            cur_idx_next = root_reg;
                        end
                        REQ_DECODE: begin
                            if (count_reg < total_reg) begin
                                byte_next      = s_tdata[7:0];
                                bits_left_next = BITS_W'(BYTE_BITS);
                                ram_rd_en      = 1'b1;
                                src_next       = SRC_FIRST;
                                state_next     = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_WALK: begin
                if (!stall) begin
                    root_entry_next = root_now;
                    if (res_hit && pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_res_next   = pend_reg;
                        m_last_next  = 1'b0;
                    end
                    if (leaf_hit) begin
                        pend_valid_next    = 1'b1;
                        pend_next.symbol   = rd_a.symbol;
                        pend_next.finished = fin_hit;
                        pend_next.bad_path = 1'b0;
                        count_next         = count_inc;
                        cur_idx_next       = root_reg;
                        src_next           = SRC_ROOT;
                        if (fin_hit) begin
                            state_next = ST_FLUSH;
                        end
                    end else begin
                        if (src_reg == SRC_CHILD) begin
                            cur_idx_next = child_idx_reg;
                        end
                        if (bits_left_reg != '0) begin
                            bits_left_next = bits_left_reg - BITS_W'(1);
                            byte_next      = {byte_reg[SYM_W-2:0], 1'b0};
                            if (bad_hit) begin
                                pend_valid_next    = 1'b1;
                                pend_next.symbol   = '0;
                                pend_next.finished = 1'b0;
                                pend_next.bad_path = 1'b1;
                                cur_idx_next       = root_reg;
                                src_next           = SRC_ROOT;
                            end else begin
                                ram_rd_en      = 1'b1;
                                ram_rd_idx_a   = child_idx;
                                child_idx_next = child_idx;
                                src_next       = SRC_CHILD;
                            end
                        end else begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end

            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_res_next      = pend_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            if (paddr[3] == CFG_REG_ROOT) begin
                root_next    = pwdata[IDX_W-1:0];
                cur_idx_next = pwdata[IDX_W-1:0];
            end else begin
                total_next = pwdata;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.symbol;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_res_reg.bad_path, m_res_reg.finished};

endmodule

// ----- src/hufd_checker.sv -----
// ----------------------------------------------------------------------------
// hufd_checker
// port level checks of the huffman tree walk decoder
// ----------------------------------------------------------------------------
module hufd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser,
    input logic        pready
);

    // a bad path word carries a zero symbol
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 8'd0)
        else $error("bad path word with non-zero symbol");

    // a word is never both finished and bad path
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("finished and bad path together");

    // the finishing symbol closes its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("finished word without tlast");

    // a stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                 && $stable(m_tuser))
        else $error("stalled output word changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind huffman_tree_decoder hufd_checker u_hufd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the huffman tree walk decoder
// ----------------------------------------------------------------------------
// loads code trees into the node table with write words, sets the symbol
// total and the root over apb, then streams code bytes, restarts, node
// rewrites and unused request kinds. every accepted input word goes through
// a bit-level model of the tree walk and the decoded words are compared
// field by field, under free flow, sender gaps, receiver stalls and both
// ----------------------------------------------------------------------------
module tb_top;
    import hufd_pkg::*;

    localparam int         QUIET_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 40;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             finished;
        logic             bad_path;
    } decoded_word_t;

    class decode_tracker;
        node_entry_t      node_tab [NODE_COUNT_DEF];
        logic [IDX_W-1:0] walk_pos;
        logic [IDX_W-1:0] root_sel;
        logic [CNT_W-1:0] sym_count;
        logic [CNT_W-1:0] sym_total;
        decoded_word_t    symbols_due [$];
        int               errors;
        int               checked;

        function new();
            walk_pos  = '0;
            root_sel  = '0;
            sym_count = '0;
            sym_total = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_reg(logic sel, logic [63:0] val);
            if (sel == CFG_REG_TOTAL) begin
                sym_total = val;
            end else begin
                root_sel = val[IDX_W-1:0];
                walk_pos = root_sel;
            end
        endfunction

        // one accepted input word: update the tree state and queue its symbols
        function void take_word(logic [1:0] req, logic [47:0] data);
            node_entry_t      cur;
            node_entry_t      nxt_e;
            logic [IDX_W-1:0] nxt;
            decoded_word_t    w;
            int               added;
            added = 0;
            if (req == REQ_WRITE) begin
                node_tab[data[16:8]] = '{right_absent: data[44], right: data[43:35],
                                         left: data[34:26], symbol: data[25:18],
                                         leaf: data[17]};
                return;
            end
            if (req == REQ_RESTART) begin
                sym_count = '0;
                walk_pos  = root_sel;
                return;
            end
            if (req != REQ_DECODE || sym_count >= sym_total)
                return;
            for (int i = BYTE_BITS - 1; i >= 0; i--) begin
                cur = node_tab[walk_pos];
                if (data[i] && cur.right_absent) begin
                    w = '{symbol: '0, last: 1'b0, finished: 1'b0, bad_path: 1'b1};
                    symbols_due.push_back(w);
                    added++;
                    walk_pos = root_sel;
                    continue;
                end
                nxt   = data[i] ? cur.right : cur.left;
                nxt_e = node_tab[nxt];
                if (nxt_e.leaf) begin
                    sym_count++;
                    walk_pos = root_sel;
                    w = '{symbol: nxt_e.symbol, last: 1'b0,
                          finished: (sym_count >= sym_total), bad_path: 1'b0};
                    symbols_due.push_back(w);
                    added++;
                    if (sym_count >= sym_total)
                        break;
                end else begin
                    walk_pos = nxt;
                end
            end
            if (added > 0)
                symbols_due[symbols_due.size() - 1].last = 1'b1;
        endfunction

        function void check_word(logic [SYM_W-1:0] sym, logic last, logic [1:0] user);
            decoded_word_t want;
            if (symbols_due.size() == 0) begin
                $error("decoded word with nothing expected: symbol %0d", sym);
                errors++;
                return;
            end
            want = symbols_due.pop_front();
            checked++;
            if (sym !== want.symbol) begin
                $error("symbol: expected %0d, got %0d", want.symbol, sym);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                errors++;
            end
            if (user[0] !== want.finished) begin
                $error("finished: expected %0d, got %0d", want.finished, user[0]);
                errors++;
            end
            if (user[1] !== want.bad_path) begin
                $error("bad_path: expected %0d, got %0d", want.bad_path, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // code_byte, node_index, node_is_leaf, node_symbol,
                            // left_child, right_child, right_absent, zero pad
    logic [1:0]  s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // symbol
    logic        m_tlast;
    logic [1:0]  m_tuser;   // finished, bad_path
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    decode_tracker    sb;
    int               src_pct = 0;
    int               snk_pct = 0;
    int               words_sent = 0;
    int               trees_built = 0;
    int               quiet = 0;
    logic [IDX_W-1:0] tree_ids [$];
    logic [IDX_W-1:0] tree_root;

    huffman_tree_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_pct);
    end

    // observe both streams and the register port, watchdog on silence
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.take_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tlast, m_tuser);
            if (psel && penable && pwrite && pready)
                sb.set_reg(paddr[3], pwdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [47:0] rand_fields();
        return {3'b000, 45'({$urandom, $urandom})};
    endfunction

    task automatic send_word(input logic [1:0] req, input logic [47:0] data);
        while ($urandom_range(0, 99) < src_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic write_node(input logic [IDX_W-1:0] idx, input logic leaf,
                              input logic [SYM_W-1:0] sym, input logic [IDX_W-1:0] lc,
                              input logic [IDX_W-1:0] rc, input logic ra);
        send_word(REQ_WRITE, {3'b000, ra, rc, lc, sym, leaf, idx, 8'($urandom)});
    endtask

    task automatic decode_byte(input logic [7:0] code);
        logic [47:0] f;
        f = rand_fields();
        f[7:0] = code;
        send_word(REQ_DECODE, f);
    endtask

    // drop valid, let every expected word arrive, then let the walk go quiet
    task automatic wait_settled();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.symbols_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic sel, input logic [63:0] val);
        logic [63:0] want;
        want = (sel == CFG_REG_ROOT) ? {55'd0, val[IDX_W-1:0]} : val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            $error("readback of register %0d: expected %0h, got %0h", sel, want, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // random tree: children point to later nodes so each code path ends in a leaf,
    // with the odd back pointer, missing right child and leaf root
    task automatic build_tree(input int k);
        logic [IDX_W-1:0] ids [$];
        bit               taken [NODE_COUNT_DEF];
        logic [IDX_W-1:0] cand;
        logic [IDX_W-1:0] lc;
        logic [IDX_W-1:0] rc;
        logic             is_leaf;
        logic             ra;
        int               lo;
        while (ids.size() < k) begin
            cand = IDX_W'($urandom_range(0, NODE_COUNT_DEF - 1));
            if (!taken[cand]) begin
                taken[cand] = 1'b1;
                ids.push_back(cand);
            end
        end
        for (int i = k - 1; i >= 0; i--) begin
            is_leaf = (i == k - 1) || (i > 0 && $urandom_range(0, 2) == 0)
                      || (i == 0 && $urandom_range(0, 9) == 0);
            lo = (is_leaf || $urandom_range(0, 15) == 0) ? 0 : i + 1;
            lc = ids[$urandom_range(lo, k - 1)];
            rc = ids[$urandom_range(lo, k - 1)];
            ra = ($urandom_range(0, 7) == 0);
            if (ra)
                rc = IDX_W'($urandom);
            write_node(ids[i], is_leaf, SYM_W'($urandom), lc, rc, ra);
        end
        tree_ids  = ids;
        tree_root = ids[0];
        trees_built++;
    endtask

    function automatic logic [63:0] pick_total();
        case ($urandom_range(0, 9))
            0: begin
                return 64'd0;
            end
            1: begin
                return '1;
            end
            2: begin
                return {$urandom, $urandom};
            end
            default: begin
                return 64'($urandom_range(1, 40));
            end
        endcase
    endfunction

    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            decode_byte(8'($urandom));
        else if (pick < 86)
            write_node(IDX_W'($urandom), 1'($urandom), SYM_W'($urandom),
                       tree_ids[$urandom_range(0, tree_ids.size() - 1)],
                       tree_ids[$urandom_range(0, tree_ids.size() - 1)],
                       ($urandom_range(0, 5) == 0));
        else if (pick < 92)
            send_word(REQ_RESTART, rand_fields());
        else if (pick < 96)
            send_word(REQ_UNUSED, rand_fields());
        else
            decode_byte($urandom_range(0, 1) ? 8'hFF : 8'h00);
    endtask

    initial begin
        int src_set [4];
        int snk_set [4];
        src_set = '{0, 74, 0, 15};
        snk_set = '{0, 0, 74, 15};
        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // small fixed tree: 0 -> (511 leaf, 5), 5 -> (6 leaf, no right)
        write_node(9'd511, 1'b1, 8'hFF, 9'd511, 9'd511, 1'b1);
        write_node(9'd0, 1'b0, 8'h00, 9'd511, 9'd5, 1'b0);
        write_node(9'd5, 1'b0, 8'h5A, 9'd6, 9'd0, 1'b1);
        write_node(9'd6, 1'b1, 8'h00, 9'd0, 9'd0, 1'b0);
        // total still zero after reset, so nothing comes out
        decode_byte(8'hFF);
        wait_settled();
        reg_write(CFG_REG_TOTAL, 64'd3);
        decode_byte(8'h00);
        decode_byte(8'h0F);
        send_word(REQ_RESTART, rand_fields());
        decode_byte(8'h4C);
        send_word(REQ_RESTART, rand_fields());
        wait_settled();
        // leaf as root
        reg_write(CFG_REG_TOTAL, '1);
        reg_write(CFG_REG_ROOT, 64'd511);
        decode_byte(8'h96);
        wait_settled();
        // leave a code half walked, then a root write has to abandon it
        reg_write(CFG_REG_ROOT, 64'd0);
        decode_byte(8'h01);
        wait_settled();
        reg_write(CFG_REG_ROOT, 64'd0);
        decode_byte(8'h80);
        decode_byte(8'hFF);
        decode_byte(8'h7F);
        send_word(REQ_UNUSED, rand_fields());
        send_word(REQ_RESTART, rand_fields());
        decode_byte(8'h40);

        for (int mode = 0; mode < 4; mode++) begin
            src_pct = src_set[mode];
            snk_pct = snk_set[mode];
            for (int sub = 0; sub < 2; sub++) begin
                build_tree(($urandom_range(0, 4) == 0) ? $urandom_range(12, 24)
                                                       : $urandom_range(3, 10));
                wait_settled();
                reg_write(CFG_REG_TOTAL, pick_total());
                reg_write(CFG_REG_ROOT, 64'(tree_root));
                repeat (45) random_word();
            end
        end
        wait_settled();

        $display("sent %0d input words over %0d random trees, checked %0d decoded words",
                 words_sent, trees_built, sb.checked);
        $display("flow patterns: free running, sender gaps, receiver stalls, both");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/hufd_pkg.sv
src/hufd_node_ram.sv
src/huffman_tree_decoder.sv
src/hufd_checker.sv
tb/tb_top.sv
